>>> hw/rtl/rc4_keystream_generator_unit_macros.svh
// Assertion macros used by the RC4 keystream generator top level.
`ifndef RC4_KEYSTREAM_GENERATOR_UNIT_MACROS_SVH
`define RC4_KEYSTREAM_GENERATOR_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RC4KG_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RC4KG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/rc4kg_pkg.sv
// Shared types and constants of the RC4 keystream generator.
package rc4kg_pkg;

   localparam int TABLE_SIZE_DEF = 256;
   localparam int BYTE_W         = 8;
   localparam int CMD_W          = 2;
   localparam int KEY_LEN_W      = 9;
   localparam int KEY_LEN_RESET  = 16;

   localparam int REQ_TDATA_W    = 24;
   localparam int RSP_TDATA_W    = 8;

   localparam int CSR_ADDR_W     = 3;
   localparam int CSR_DATA_W     = 32;
   localparam int CSR_IDX_W      = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_IDX_KEY_LENGTH = 1'b0;

   localparam logic [CMD_W-1:0] CMD_LOAD     = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SCHEDULE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_GENERATE = 2'd2;

   // Datapath operations, one per controller step.
   typedef enum logic [3:0] {
      OP_NONE,
      OP_KEY_WR,
      OP_IDENT,
      OP_KRD_K,
      OP_KRD_J,
      OP_KWR_K,
      OP_KWR_J,
      OP_GRD_I,
      OP_GRD_J,
      OP_GWR_I,
      OP_GWR_J
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      capture;
      logic      res_load;
      logic      res_status;
   } dp_cmd_type;

   typedef struct packed {
      logic keyed;
      logic sweep_last;
      logic out_free;
   } dp_status_type;

endpackage

>>> hw/rtl/rc4kg_csr.sv
// Configuration register block holding the key length.
module rc4kg_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [rc4kg_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [rc4kg_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [rc4kg_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                               csr_pready,
   output logic [rc4kg_pkg::KEY_LEN_W-1:0]    key_length
);
   import rc4kg_pkg::*;

   logic [KEY_LEN_W-1:0] key_length_ff;
   logic [KEY_LEN_W-1:0] key_length_in;
   logic [CSR_IDX_W-1:0] reg_idx;
   logic                 wr_fire;

   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign wr_fire    = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign key_length = key_length_ff;

   always_comb begin
      key_length_in = key_length_ff;
      if (wr_fire && (reg_idx == CSR_IDX_KEY_LENGTH)) begin
         key_length_in = csr_pwdata[KEY_LEN_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (reg_idx == CSR_IDX_KEY_LENGTH) begin
         csr_prdata = CSR_DATA_W'(key_length_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_length_ff <= KEY_LEN_W'(KEY_LEN_RESET);
      end else begin
         key_length_ff <= key_length_in;
      end
   end

endmodule

>>> hw/rtl/rc4kg_datapath.sv
// Datapath: permutation memory, key store, indices and result register.
module rc4kg_datapath #(
   parameter int TABLE_SIZE = rc4kg_pkg::TABLE_SIZE_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [rc4kg_pkg::KEY_LEN_W-1:0]   key_length,
   input  logic [rc4kg_pkg::BYTE_W-1:0]      req_key_index,
   input  logic [rc4kg_pkg::BYTE_W-1:0]      req_key_byte,
   input  rc4kg_pkg::dp_cmd_type             dp_cmd,
   output rc4kg_pkg::dp_status_type          dp_status,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [rc4kg_pkg::BYTE_W-1:0]      rsp_keystream_byte,
   output logic                              rsp_status
);
   import rc4kg_pkg::*;

   localparam int IDX_W = $clog2(TABLE_SIZE);
   localparam int LEN_W = IDX_W + 1;

   logic [BYTE_W-1:0] perm_mem [TABLE_SIZE];
   logic [BYTE_W-1:0] key_mem  [TABLE_SIZE];
   logic [TABLE_SIZE-1:0] key_vld_ff;

   logic [IDX_W-1:0]  kidx_ff, kidx_in;
   logic [BYTE_W-1:0] kbyte_ff, kbyte_in;
   logic [IDX_W-1:0]  i_ff, i_in;
   logic [IDX_W-1:0]  j_ff, j_in;
   logic [IDX_W-1:0]  k_ff, k_in;
   logic [IDX_W-1:0]  pos_ff, pos_in;
   logic [BYTE_W-1:0] sa_ff, sa_in;
   logic [BYTE_W-1:0] sb_ff, sb_in;
   logic [IDX_W-1:0]  t_ff, t_in;
   logic [BYTE_W-1:0] ks_ff, ks_in;
   logic              keyed_ff, keyed_in;
   logic              rsp_tvalid_ff, rsp_tvalid_in;
   logic [BYTE_W-1:0] rsp_ks_ff, rsp_ks_in;
   logic              rsp_status_ff, rsp_status_in;

   logic [BYTE_W-1:0] rd_a_ff, rd_b_ff;
   logic [BYTE_W-1:0] key_rd_ff;
   logic              key_rd_vld_ff;

   logic [IDX_W-1:0]  rd_a_addr, rd_b_addr, wr_addr;
   logic [BYTE_W-1:0] wr_data;
   logic              wr_en;
   logic              key_wr;

   logic [LEN_W-1:0]  len_eff;
   logic [LEN_W-1:0]  pos_inc;
   logic [IDX_W-1:0]  pos_next;
   logic [IDX_W-1:0]  i_inc;
   logic [IDX_W-1:0]  j_gen;
   logic [IDX_W-1:0]  j_ksa;
   logic [IDX_W-1:0]  t_sum;
   logic [BYTE_W-1:0] key_val;
   logic [BYTE_W-1:0] ks_bypass;
   logic              sweep_last;
   logic              out_free;

   // A key store entry never written reads as zero.
   assign key_val    = key_rd_vld_ff ? key_rd_ff : '0;
   assign sweep_last = (k_ff == IDX_W'(TABLE_SIZE - 1));
   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign key_wr     = (dp_cmd.op == OP_KEY_WR);

   assign dp_status.keyed      = keyed_ff;
   assign dp_status.sweep_last = sweep_last;
   assign dp_status.out_free   = out_free;

   assign rsp_tvalid         = rsp_tvalid_ff;
   assign rsp_keystream_byte = rsp_ks_ff;
   assign rsp_status         = rsp_status_ff;

   always_comb begin
      if (key_length == '0) begin
         len_eff = LEN_W'(1);
      end else if (key_length > KEY_LEN_W'(TABLE_SIZE)) begin
         len_eff = LEN_W'(TABLE_SIZE);
      end else begin
         len_eff = LEN_W'(key_length);
      end
   end

   assign pos_inc  = {1'b0, pos_ff} + LEN_W'(1);
   assign pos_next = (pos_inc >= len_eff) ? '0 : pos_inc[IDX_W-1:0];
   assign i_inc    = i_ff + IDX_W'(1);
   assign j_gen    = j_ff + IDX_W'(rd_a_ff);
   assign j_ksa    = j_ff + IDX_W'(rd_a_ff) + IDX_W'(key_val);
   assign t_sum    = IDX_W'(sa_ff) + IDX_W'(rd_b_ff);

   // The output read was issued while S[i] was being rewritten and before
   // S[j] was, so a hit on either swapped slot takes the swapped value.
   always_comb begin
      if (t_ff == i_ff) begin
         ks_bypass = sb_ff;
      end else if (t_ff == j_ff) begin
         ks_bypass = sa_ff;
      end else begin
         ks_bypass = rd_a_ff;
      end
   end

   // Memory port steering.
   always_comb begin
      rd_a_addr = '0;
      rd_b_addr = '0;
      wr_en     = 1'b0;
      wr_addr   = '0;
      wr_data   = '0;
      unique case (dp_cmd.op)
         OP_IDENT: begin
            wr_en   = 1'b1;
            wr_addr = k_ff;
            wr_data = BYTE_W'(k_ff);
         end
         OP_KRD_K: begin
            rd_a_addr = k_ff;
         end
         OP_KRD_J: begin
            rd_b_addr = j_ksa;
         end
         OP_KWR_K: begin
            wr_en   = 1'b1;
            wr_addr = k_ff;
            wr_data = rd_b_ff;
         end
         OP_KWR_J: begin
            wr_en   = 1'b1;
            wr_addr = j_ff;
            wr_data = sa_ff;
         end
         OP_GRD_I: begin
            rd_a_addr = i_inc;
         end
         OP_GRD_J: begin
            rd_b_addr = j_gen;
         end
         OP_GWR_I: begin
            wr_en     = 1'b1;
            wr_addr   = i_ff;
            wr_data   = rd_b_ff;
            rd_a_addr = t_sum;
         end
         OP_GWR_J: begin
            wr_en   = 1'b1;
            wr_addr = j_ff;
            wr_data = sa_ff;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      kidx_in       = kidx_ff;
      kbyte_in      = kbyte_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      k_in          = k_ff;
      pos_in        = pos_ff;
      sa_in         = sa_ff;
      sb_in         = sb_ff;
      t_in          = t_ff;
      ks_in         = ks_ff;
      keyed_in      = keyed_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_ks_in     = rsp_ks_ff;
      rsp_status_in = rsp_status_ff;

      if (dp_cmd.capture) begin
         kidx_in  = IDX_W'(req_key_index);
         kbyte_in = req_key_byte;
         ks_in    = '0;
      end

      unique case (dp_cmd.op)
         OP_IDENT: begin
            k_in = k_ff + IDX_W'(1);
            if (sweep_last) begin
               j_in   = '0;
               pos_in = '0;
            end
         end
         OP_KRD_J: begin
            sa_in = rd_a_ff;
            j_in  = j_ksa;
         end
         OP_KWR_J: begin
            k_in   = k_ff + IDX_W'(1);
            pos_in = pos_next;
            if (sweep_last) begin
               i_in     = '0;
               j_in     = '0;
               keyed_in = 1'b1;
            end
         end
         OP_GRD_I: begin
            i_in = i_inc;
         end
         OP_GRD_J: begin
            sa_in = rd_a_ff;
            j_in  = j_gen;
         end
         OP_GWR_I: begin
            sb_in = rd_b_ff;
            t_in  = t_sum;
         end
         OP_GWR_J: begin
            ks_in = ks_bypass;
         end
         default: begin
         end
      endcase

      if (dp_cmd.res_load) begin
         rsp_tvalid_in = 1'b1;
         rsp_ks_in     = ks_ff;
         rsp_status_in = dp_cmd.res_status;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         perm_mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= perm_mem[rd_a_addr];
      rd_b_ff <= perm_mem[rd_b_addr];
   end

   always_ff @(posedge clock) begin
      if (key_wr) begin
         key_mem[kidx_ff] <= kbyte_ff;
      end
      key_rd_ff <= key_mem[pos_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_vld_ff    <= '0;
         key_rd_vld_ff <= 1'b0;
      end else begin
         if (key_wr) begin
            key_vld_ff[kidx_ff] <= 1'b1;
         end
         key_rd_vld_ff <= key_vld_ff[pos_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         i_ff          <= '0;
         j_ff          <= '0;
         k_ff          <= '0;
         pos_ff        <= '0;
         keyed_ff      <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         i_ff          <= i_in;
         j_ff          <= j_in;
         k_ff          <= k_in;
         pos_ff        <= pos_in;
         keyed_ff      <= keyed_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      kidx_ff       <= kidx_in;
      kbyte_ff      <= kbyte_in;
      sa_ff         <= sa_in;
      sb_ff         <= sb_in;
      t_ff          <= t_in;
      ks_ff         <= ks_in;
      rsp_ks_ff     <= rsp_ks_in;
      rsp_status_ff <= rsp_status_in;
   end

endmodule

>>> hw/rtl/rc4kg_ctrl.sv
// Controller state machine sequencing load, key schedule and generate.
module rc4kg_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [rc4kg_pkg::CMD_W-1:0]    req_cmd,
   input  rc4kg_pkg::dp_status_type       dp_status,
   output rc4kg_pkg::dp_cmd_type          dp_cmd
);
   import rc4kg_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_KEY_WR,
      ST_IDENT,
      ST_KRD_K,
      ST_KRD_J,
      ST_KWR_K,
      ST_KWR_J,
      ST_GRD_I,
      ST_GRD_J,
      ST_GWR_I,
      ST_GWR_J,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      refused_ff, refused_in;
   logic      accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in           = state_ff;
      refused_in         = refused_ff;
      dp_cmd.op          = OP_NONE;
      dp_cmd.capture     = accept;
      dp_cmd.res_load    = 1'b0;
      dp_cmd.res_status  = refused_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               refused_in = 1'b0;
               unique case (req_cmd)
                  CMD_LOAD: begin
                     state_in = ST_KEY_WR;
                  end
                  CMD_SCHEDULE: begin
                     state_in = ST_IDENT;
                  end
                  CMD_GENERATE: begin
                     if (dp_status.keyed) begin
                        state_in = ST_GRD_I;
                     end else begin
                        refused_in = 1'b1;
                        state_in   = ST_FINISH;
                     end
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end
         ST_KEY_WR: begin
            dp_cmd.op = OP_KEY_WR;
            state_in  = ST_FINISH;
         end
         ST_IDENT: begin
            dp_cmd.op = OP_IDENT;
            if (dp_status.sweep_last) begin
               state_in = ST_KRD_K;
            end
         end
         ST_KRD_K: begin
            dp_cmd.op = OP_KRD_K;
            state_in  = ST_KRD_J;
         end
         ST_KRD_J: begin
            dp_cmd.op = OP_KRD_J;
            state_in  = ST_KWR_K;
         end
         ST_KWR_K: begin
            dp_cmd.op = OP_KWR_K;
            state_in  = ST_KWR_J;
         end
         ST_KWR_J: begin
            dp_cmd.op = OP_KWR_J;
            state_in  = dp_status.sweep_last ? ST_FINISH : ST_KRD_K;
         end
         ST_GRD_I: begin
            dp_cmd.op = OP_GRD_I;
            state_in  = ST_GRD_J;
         end
         ST_GRD_J: begin
            dp_cmd.op = OP_GRD_J;
            state_in  = ST_GWR_I;
         end
         ST_GWR_I: begin
            dp_cmd.op = OP_GWR_I;
            state_in  = ST_GWR_J;
         end
         ST_GWR_J: begin
            dp_cmd.op = OP_GWR_J;
            state_in  = ST_FINISH;
         end
         ST_FINISH: begin
            // Hold here until the result register can take the result.
            if (dp_status.out_free) begin
               dp_cmd.res_load = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         refused_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         refused_ff <= refused_in;
      end
   end

endmodule

>>> hw/rtl/rc4_keystream_generator_unit.sv
// Top level of the RC4 keystream generator.
// The engine takes one command transaction at a time and returns exactly one
// result transaction for each. A load writes one key byte. A generate makes
// two registered permutation reads, then the two swap writes with the output
// read issued beside the first, then the result load; a generate refused
// before the first schedule, or an unused command code, goes straight to the
// result load. A schedule writes the identity permutation into every entry,
// then runs the key-scheduling pass, which for each entry reads S[k] and S[j]
// and writes both back one after the other through the permutation memory's
// single write port. The permutation memory needs no clearing pass after
// reset, since generate is refused until a schedule has rewritten it; key
// store entries never written read as zero. The result register lets the
// next command be accepted while a result waits to be taken. The key_length
// register lies at byte address 0; write it only while the engine is idle.
`include "rc4_keystream_generator_unit_macros.svh"

module rc4_keystream_generator_unit #(
   parameter int TABLE_SIZE = rc4kg_pkg::TABLE_SIZE_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [1:0] cmd, [9:2] key_index, [17:10] key_byte, [23:18] zero
   input  logic [rc4kg_pkg::REQ_TDATA_W-1:0]  req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [7:0] keystream_byte
   output logic [rc4kg_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // [0] status
   output logic                               rsp_tuser,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [rc4kg_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [rc4kg_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [rc4kg_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                               csr_pready
);
   import rc4kg_pkg::*;

   logic [CMD_W-1:0]     req_cmd;
   logic [BYTE_W-1:0]    req_key_index;
   logic [BYTE_W-1:0]    req_key_byte;
   logic [KEY_LEN_W-1:0] key_length;
   dp_cmd_type           dp_cmd;
   dp_status_type        dp_status;

   assign req_cmd       = req_tdata[CMD_W-1:0];
   assign req_key_index = req_tdata[CMD_W+BYTE_W-1:CMD_W];
   assign req_key_byte  = req_tdata[CMD_W+2*BYTE_W-1:CMD_W+BYTE_W];

   rc4kg_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .key_length  (key_length)
   );

   rc4kg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_cmd    (req_cmd),
      .dp_status  (dp_status),
      .dp_cmd     (dp_cmd)
   );

   rc4kg_datapath #(
      .TABLE_SIZE (TABLE_SIZE)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .key_length         (key_length),
      .req_key_index      (req_key_index),
      .req_key_byte       (req_key_byte),
      .dp_cmd             (dp_cmd),
      .dp_status          (dp_status),
      .rsp_tvalid         (rsp_tvalid),
      .rsp_tready         (rsp_tready),
      .rsp_keystream_byte (rsp_tdata),
      .rsp_status         (rsp_tuser)
   );

   `RC4KG_ASSERT_NEXT(a_one_in_flight, clock, reset, req_tvalid && req_tready, !req_tready, "command accepted while another is in progress")
   `RC4KG_ASSERT_SAME(a_load_when_free, clock, reset, dp_cmd.res_load, dp_status.out_free, "result loaded over an untaken result")
   `RC4KG_ASSERT_SAME(a_refuse_unkeyed, clock, reset, dp_cmd.res_load && dp_cmd.res_status, !dp_status.keyed, "generate refused although keyed")
   `RC4KG_ASSERT_SAME(a_refused_zero, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata == '0, "refused generate carries a nonzero byte")

endmodule

>>> tb/tb_rc4_keystream_generator_unit.sv
// Self-checking testbench for the RC4 keystream generator unit.
`timescale 1ns / 1ps

module tb_rc4_keystream_generator_unit;
   import rc4kg_pkg::*;

   localparam logic [CMD_W-1:0]      CMD_UNUSED      = 2'd3;
   localparam logic [CSR_ADDR_W-1:0] ADDR_KEY_LENGTH = {CSR_IDX_KEY_LENGTH, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] ADDR_UNMAPPED   = 3'd4;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int HOLD_START   = 15000;
   localparam int HOLD_LEN     = 3000;
   localparam int N_PHASES     = 9;
   localparam int PHASE_ITEMS  = 200;
   localparam int N_DIRECTED   = 22;

   typedef struct packed {
      logic [BYTE_W-1:0] ks;
      logic              status;
   } ks_result_type;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [BYTE_W-1:0] kidx;
      logic [BYTE_W-1:0] kbyte;
      logic              typed;
      logic [BYTE_W-1:0] ks;
      logic              status;
   } dir_row_type;

   logic                    clock;
   logic                    reset       = 1'b1;
   logic                    req_tvalid  = 1'b0;
   logic                    req_tready;
   logic [REQ_TDATA_W-1:0]  req_tdata   = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready  = 1'b0;
   logic [RSP_TDATA_W-1:0]  rsp_tdata;
   logic                    rsp_tuser;
   logic                    csr_psel    = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0]   csr_paddr   = '0;
   logic [CSR_DATA_W-1:0]   csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0]   csr_prdata;
   logic                    csr_pready;

   // Shadow copy of the cipher state.
   logic [BYTE_W-1:0]    perm_tab [0:255];
   logic [BYTE_W-1:0]    key_mem  [0:255];
   logic [BYTE_W-1:0]    ptr_i;
   logic [BYTE_W-1:0]    ptr_j;
   logic                 is_keyed;
   logic [KEY_LEN_W-1:0] key_len;

   ks_result_type pending_keystream [$];

   int fail_count  = 0;
   int cycle_count = 0;
   int n_items     = 0;
   int n_results   = 0;
   int n_sched     = 0;
   int n_gen       = 0;
   int n_refused   = 0;
   int burst_left  = 0;
   int key_len_plan [N_PHASES] = '{1, 0, 256, 511, 3, 257, 5, 40, 0};

   // Expected values are typed in only for results that need no keystream.
   dir_row_type dir_rows [0:N_DIRECTED-1] = '{
      '{CMD_GENERATE, 8'h00, 8'h00, 1'b1, 8'h00, 1'b1},
      '{CMD_UNUSED,   8'hFF, 8'hFF, 1'b1, 8'h00, 1'b0},
      '{CMD_LOAD,     8'h00, 8'h00, 1'b1, 8'h00, 1'b0},
      '{CMD_LOAD,     8'hFF, 8'hFF, 1'b1, 8'h00, 1'b0},
      '{CMD_LOAD,     8'h01, 8'hFF, 1'b1, 8'h00, 1'b0},
      '{CMD_LOAD,     8'h0F, 8'h80, 1'b1, 8'h00, 1'b0},
      '{CMD_LOAD,     8'h02, 8'h01, 1'b1, 8'h00, 1'b0},
      '{CMD_GENERATE, 8'hAA, 8'h55, 1'b1, 8'h00, 1'b1},
      '{CMD_SCHEDULE, 8'h00, 8'h00, 1'b1, 8'h00, 1'b0},
      '{CMD_GENERATE, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0},
      '{CMD_GENERATE, 8'hFF, 8'hFF, 1'b0, 8'h00, 1'b0},
      '{CMD_GENERATE, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0},
      '{CMD_GENERATE, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0},
      '{CMD_GENERATE, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0},
      '{CMD_LOAD,     8'h03, 8'hA5, 1'b1, 8'h00, 1'b0},
      '{CMD_GENERATE, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0},
      '{CMD_UNUSED,   8'h00, 8'h00, 1'b1, 8'h00, 1'b0},
      '{CMD_GENERATE, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0},
      '{CMD_SCHEDULE, 8'hFF, 8'hFF, 1'b1, 8'h00, 1'b0},
      '{CMD_GENERATE, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0},
      '{CMD_GENERATE, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0},
      '{CMD_GENERATE, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0}
   };

   rc4_keystream_generator_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int eff_key_len();
      int len;
      len = int'(key_len);
      if (len < 1) len = 1;
      if (len > 256) len = 256;
      return len;
   endfunction

   function automatic void rc4_rekey();
      int                len;
      int                pos;
      logic [BYTE_W-1:0] j;
      logic [BYTE_W-1:0] tmp;
      len = eff_key_len();
      for (int k = 0; k < 256; k++) perm_tab[k] = k[BYTE_W-1:0];
      j   = '0;
      pos = 0;
      for (int k = 0; k < 256; k++) begin
         j           = j + perm_tab[k] + key_mem[pos];
         tmp         = perm_tab[k];
         perm_tab[k] = perm_tab[j];
         perm_tab[j] = tmp;
         pos++;
         if (pos >= len) pos = 0;
      end
      ptr_i    = '0;
      ptr_j    = '0;
      is_keyed = 1'b1;
   endfunction

   function automatic ks_result_type rc4_compute(logic [CMD_W-1:0] cmd,
                                                 logic [BYTE_W-1:0] kidx,
                                                 logic [BYTE_W-1:0] kbyte);
      ks_result_type     r;
      logic [BYTE_W-1:0] ni;
      logic [BYTE_W-1:0] nj;
      logic [BYTE_W-1:0] tmp;
      logic [BYTE_W-1:0] t;
      r = '0;
      case (cmd)
         CMD_LOAD: begin
            key_mem[kidx] = kbyte;
         end
         CMD_SCHEDULE: begin
            rc4_rekey();
         end
         CMD_GENERATE: begin
            if (is_keyed) begin
               ni           = ptr_i + 8'd1;
               nj           = ptr_j + perm_tab[ni];
               tmp          = perm_tab[ni];
               perm_tab[ni] = perm_tab[nj];
               perm_tab[nj] = tmp;
               ptr_i        = ni;
               ptr_j        = nj;
               t            = perm_tab[ni] + perm_tab[nj];
               r.ks         = perm_tab[t];
            end else begin
               r.status = 1'b1;
            end
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   task automatic report_fail(string msg);
      fail_count++;
      if (fail_count <= 10) $display("%s", msg);
   endtask

   // Offers one command in bursts with random gaps and predicts its result on acceptance.
   task automatic send_cmd(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] kidx,
                           logic [BYTE_W-1:0] kbyte, logic typed, ks_result_type typed_val);
      int            gap;
      ks_result_type r;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_TDATA_W - CMD_W - 2 * BYTE_W){1'b0}}, kbyte, kidx, cmd};
      do @(posedge clock); while (!req_tready);
      burst_left--;
      n_items++;
      if (cmd == CMD_SCHEDULE) n_sched++;
      if (cmd == CMD_GENERATE) begin
         n_gen++;
         if (!is_keyed) n_refused++;
      end
      r = rc4_compute(cmd, kidx, kbyte);
      if (typed) r = typed_val;
      pending_keystream.push_back(r);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_keystream.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (addr == ADDR_KEY_LENGTH) key_len = data[KEY_LEN_W-1:0];
      @(posedge clock);
   endtask

   // Stimulus: directed table, then phases of random traffic under different key lengths.
   initial begin
      int                len_set;
      int                n_pre;
      int                quota;
      int                r;
      int                eff;
      logic [CMD_W-1:0]  cmd;
      logic [BYTE_W-1:0] kidx;
      logic [BYTE_W-1:0] kbyte;
      ks_result_type     tv;

      for (int k = 0; k < 256; k++) begin
         perm_tab[k] = k[BYTE_W-1:0];
         key_mem[k]  = '0;
      end
      ptr_i    = '0;
      ptr_j    = '0;
      is_keyed = 1'b0;
      key_len  = KEY_LEN_RESET[KEY_LEN_W-1:0];

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int d = 0; d < N_DIRECTED; d++) begin
         tv.ks     = dir_rows[d].ks;
         tv.status = dir_rows[d].status;
         send_cmd(dir_rows[d].cmd, dir_rows[d].kidx, dir_rows[d].kbyte, dir_rows[d].typed, tv);
      end
      drain();

      for (int p = 0; p < N_PHASES; p++) begin
         len_set = (p == N_PHASES - 1) ? $urandom_range(1, 256) : key_len_plan[p];
         csr_write(ADDR_UNMAPPED, $urandom());
         csr_write(ADDR_KEY_LENGTH, {(CSR_DATA_W - KEY_LEN_W)'($urandom_range(0, 8388607)),
                                     len_set[KEY_LEN_W-1:0]});
         eff = eff_key_len();

         // A well-formed opening: load key bytes, then schedule.
         n_pre = (key_len == 256) ? 256 : $urandom_range(1, 12);
         for (int n = 0; n < n_pre; n++) begin
            kidx = (n_pre == 256) ? n[BYTE_W-1:0] : BYTE_W'($urandom_range(0, eff - 1));
            send_cmd(CMD_LOAD, kidx, BYTE_W'($urandom_range(0, 255)), 1'b0, '0);
         end
         send_cmd(CMD_SCHEDULE, BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)),
                  1'b0, '0);

         quota = (n_pre + 40 > PHASE_ITEMS) ? n_pre + 40 : PHASE_ITEMS;
         for (int n = n_pre + 1; n < quota; n++) begin
            r = $urandom_range(0, 99);
            if (r < 3) cmd = CMD_SCHEDULE;
            else if (r < 20) cmd = CMD_LOAD;
            else if (r < 23) cmd = CMD_UNUSED;
            else cmd = CMD_GENERATE;
            if (cmd == CMD_LOAD && $urandom_range(0, 9) < 7)
               kidx = BYTE_W'($urandom_range(0, eff - 1));
            else kidx = BYTE_W'($urandom_range(0, 255));
            kbyte = BYTE_W'($urandom_range(0, 255));
            send_cmd(cmd, kidx, kbyte, 1'b0, '0);
         end
         drain();
      end

      repeat (20) @(posedge clock);
      if (pending_keystream.size() != 0)
         report_fail($sformatf("%0d result transactions never arrived",
                               pending_keystream.size()));
      $display("Covered %0d command transactions: %0d schedules, %0d generates (%0d refused).",
               n_items, n_sched, n_gen, n_refused);
      $display("Checked %0d results over %0d key-length settings; %0d failures.",
               n_results, N_PHASES + 1, fail_count);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Receiver: a changing stall pattern, plus one long hold-off to back up the input.
   initial begin
      int          rx_cycle;
      int          mode;
      logic [31:0] mask;
      rx_cycle = 0;
      mode     = 0;
      mask     = '1;
      forever begin
         @(posedge clock);
         rx_cycle++;
         if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_LEN) begin
            rsp_tready <= 1'b0;
         end else begin
            if (rx_cycle % 64 == 0) begin
               mode = $urandom_range(0, 2);
               mask = $urandom();
            end
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= mask[rx_cycle % 32];
               default: rsp_tready <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   // Each result transaction is matched against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         n_results++;
         if (pending_keystream.size() == 0) begin
            report_fail($sformatf("unexpected result transaction: ks=%02h status=%0b",
                                  rsp_tdata, rsp_tuser));
         end else begin
            if (rsp_tdata !== pending_keystream[0].ks || rsp_tuser !== pending_keystream[0].status)
               report_fail($sformatf("result %0d: ks exp %02h got %02h, status exp %0b got %0b",
                                     n_results, pending_keystream[0].ks, rsp_tdata,
                                     pending_keystream[0].status, rsp_tuser));
            void'(pending_keystream.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding.",
                  cycle_count, pending_keystream.size());
         $display("status: fail");
         $finish;
      end
   end

endmodule
